>>> rtl/salist_pkg.sv
// ----------------------------------------------------------------------------
// salist_pkg
// Shared types, codes and helpers for the sorted array list engine.
// ----------------------------------------------------------------------------
package salist_pkg;

  // default sizing
  localparam int DEPTH_DEF        = 64;
  localparam int PAYLOAD_BITS_DEF = 64;

  // fixed field widths
  localparam int KEY_BITS = 32;
  localparam int POS_BITS = 7;
  localparam int CNT_BITS = 7;
  localparam int ACT_BITS = 3;

  // operation codes carried on the input tuser
  typedef enum logic [ACT_BITS-1:0] {
    OP_INS_END    = 3'd0,
    OP_INS_FRONT  = 3'd1,
    OP_INS_SORTED = 3'd2,
    OP_RM_KEY     = 3'd3,
    OP_RM_FRONT   = 3'd4,
    OP_RM_END     = 3'd5,
    OP_READ_POS   = 3'd6,
    OP_FIND_KEY   = 3'd7
  } action_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_UP_RD,
    ST_UP_WR,
    ST_DN_RD,
    ST_DN_WR,
    ST_WRITE,
    ST_READ,
    ST_RESP
  } state_t;

  // status of one result item
  typedef struct packed {
    logic                ok;
    logic [CNT_BITS-1:0] entry_count;
    logic                is_full;
    logic                is_empty;
  } res_stat_t;

  // signed key compare
  function automatic logic key_less(input logic [KEY_BITS-1:0] a,
                                    input logic [KEY_BITS-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

>>> rtl/salist_store.sv
// ----------------------------------------------------------------------------
// salist_store
// Record memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module salist_store #(
  parameter int DEPTH = salist_pkg::DEPTH_DEF,
  parameter int WIDTH = salist_pkg::KEY_BITS + salist_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]      rd_data,
  input  logic                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]      wr_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/salist_seq.sv
// ----------------------------------------------------------------------------
// salist_seq
// Operation sequencer: scans, shifts and writes the record memory one entry
// at a time and keeps the fill count.
// ----------------------------------------------------------------------------
module salist_seq #(
  parameter int DEPTH        = salist_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = salist_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input item
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  salist_pkg::action_t                  in_action,
  input  logic [salist_pkg::KEY_BITS-1:0]      in_key,
  input  logic [PAYLOAD_BITS-1:0]              in_payload,
  input  logic [salist_pkg::POS_BITS-1:0]      in_position,
  // memory
  output logic                                 mem_rd_en,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] mem_rd_addr,
  input  logic [salist_pkg::KEY_BITS+PAYLOAD_BITS-1:0] mem_rd_data,
  output logic                                 mem_wr_en,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] mem_wr_addr,
  output logic [salist_pkg::KEY_BITS+PAYLOAD_BITS-1:0] mem_wr_data,
  // result item
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output salist_pkg::res_stat_t                res_stat,
  output logic [salist_pkg::KEY_BITS-1:0]      res_key,
  output logic [PAYLOAD_BITS-1:0]              res_payload
);

  localparam int KW = salist_pkg::KEY_BITS;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW = (CW > salist_pkg::POS_BITS) ? CW : salist_pkg::POS_BITS;

  salist_pkg::state_t  state_r, state_nxt;
  salist_pkg::action_t op_r, op_nxt;
  logic [KW-1:0]           key_r, key_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [CW-1:0]           tgt_r, tgt_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    ok_r, ok_nxt;
  logic [KW-1:0]           fkey_r, fkey_nxt;
  logic [PAYLOAD_BITS-1:0] fpay_r, fpay_nxt;

  logic                    accept;
  logic                    full_w, empty_w;
  logic                    scan_more, up_more, dn_more, pos_ok, key_eq;
  logic [CW-1:0]           idx_inc, idx_dec;
  logic [XW-1:0]           pos_x, pos_m1;
  logic [KW-1:0]           rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;

  // shared conditions
  assign accept    = in_valid && in_ready;
  assign full_w    = (cnt_r == CW'(DEPTH));
  assign empty_w   = (cnt_r == '0);
  assign idx_inc   = idx_r + CW'(1);
  assign idx_dec   = idx_r - CW'(1);
  assign scan_more = (idx_r < cnt_r);
  assign up_more   = (idx_r > tgt_r);
  assign dn_more   = (idx_inc < cnt_r);
  assign pos_x     = XW'(in_position);
  assign pos_m1    = pos_x - XW'(1);
  assign pos_ok    = (pos_x != '0) && (pos_x <= XW'(cnt_r));
  assign rd_key    = mem_rd_data[KW-1:0];
  assign rd_pay    = mem_rd_data[KW +: PAYLOAD_BITS];
  assign key_eq    = (rd_key == key_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      salist_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_action)
            salist_pkg::OP_INS_END:
              state_nxt = full_w ? salist_pkg::ST_RESP : salist_pkg::ST_WRITE;
            salist_pkg::OP_INS_FRONT:
              state_nxt = full_w ? salist_pkg::ST_RESP : salist_pkg::ST_UP_RD;
            salist_pkg::OP_INS_SORTED:
              state_nxt = full_w ? salist_pkg::ST_RESP : salist_pkg::ST_SCAN_RD;
            salist_pkg::OP_RM_KEY, salist_pkg::OP_FIND_KEY:
              state_nxt = salist_pkg::ST_SCAN_RD;
            salist_pkg::OP_RM_FRONT:
              state_nxt = empty_w ? salist_pkg::ST_RESP : salist_pkg::ST_DN_RD;
            salist_pkg::OP_READ_POS:
              state_nxt = pos_ok ? salist_pkg::ST_READ : salist_pkg::ST_RESP;
            default:
              state_nxt = salist_pkg::ST_RESP;
          endcase
        end
      end
      salist_pkg::ST_SCAN_RD: begin
        if (scan_more) begin
          state_nxt = salist_pkg::ST_SCAN_CMP;
        end else if (op_r == salist_pkg::OP_INS_SORTED) begin
          state_nxt = salist_pkg::ST_UP_RD;
        end else begin
          state_nxt = salist_pkg::ST_RESP;
        end
      end
      salist_pkg::ST_SCAN_CMP: begin
        case (op_r)
          salist_pkg::OP_INS_SORTED:
            state_nxt = salist_pkg::key_less(rd_key, key_r) ?
                        salist_pkg::ST_SCAN_RD : salist_pkg::ST_UP_RD;
          salist_pkg::OP_RM_KEY:
            state_nxt = key_eq ? salist_pkg::ST_DN_RD : salist_pkg::ST_SCAN_RD;
          default:
            state_nxt = key_eq ? salist_pkg::ST_RESP : salist_pkg::ST_SCAN_RD;
        endcase
      end
      salist_pkg::ST_UP_RD:
        state_nxt = up_more ? salist_pkg::ST_UP_WR : salist_pkg::ST_WRITE;
      salist_pkg::ST_UP_WR:
        state_nxt = salist_pkg::ST_UP_RD;
      salist_pkg::ST_DN_RD:
        state_nxt = dn_more ? salist_pkg::ST_DN_WR : salist_pkg::ST_RESP;
      salist_pkg::ST_DN_WR:
        state_nxt = salist_pkg::ST_DN_RD;
      salist_pkg::ST_WRITE:
        state_nxt = salist_pkg::ST_RESP;
      salist_pkg::ST_READ:
        state_nxt = salist_pkg::ST_RESP;
      salist_pkg::ST_RESP: begin
        if (res_ready) begin
          state_nxt = salist_pkg::ST_IDLE;
        end
      end
      default:
        state_nxt = salist_pkg::ST_IDLE;
    endcase
  end

  // datapath register updates
  always_comb begin
    op_nxt   = op_r;
    key_nxt  = key_r;
    pay_nxt  = pay_r;
    idx_nxt  = idx_r;
    tgt_nxt  = tgt_r;
    cnt_nxt  = cnt_r;
    ok_nxt   = ok_r;
    fkey_nxt = fkey_r;
    fpay_nxt = fpay_r;
    case (state_r)
      salist_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt   = in_action;
          key_nxt  = in_key;
          pay_nxt  = in_payload;
          ok_nxt   = 1'b0;
          fkey_nxt = '0;
          fpay_nxt = '0;
          idx_nxt  = '0;
          tgt_nxt  = '0;
          case (in_action)
            salist_pkg::OP_INS_END:   tgt_nxt = cnt_r;
            salist_pkg::OP_INS_FRONT: idx_nxt = cnt_r;
            salist_pkg::OP_RM_END: begin
              if (!empty_w) begin
                cnt_nxt = cnt_r - CW'(1);
                ok_nxt  = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      salist_pkg::ST_SCAN_RD: begin
        // nothing smaller left: sorted insert goes at the end
        if (!scan_more) begin
          tgt_nxt = cnt_r;
          idx_nxt = cnt_r;
        end
      end
      salist_pkg::ST_SCAN_CMP: begin
        case (op_r)
          salist_pkg::OP_INS_SORTED: begin
            if (salist_pkg::key_less(rd_key, key_r)) begin
              idx_nxt = idx_inc;
            end else begin
              tgt_nxt = idx_r;
              idx_nxt = cnt_r;
            end
          end
          salist_pkg::OP_RM_KEY: begin
            if (!key_eq) begin
              idx_nxt = idx_inc;
            end
          end
          default: begin
            if (key_eq) begin
              ok_nxt   = 1'b1;
              fkey_nxt = rd_key;
              fpay_nxt = rd_pay;
            end else begin
              idx_nxt = idx_inc;
            end
          end
        endcase
      end
      salist_pkg::ST_UP_WR: idx_nxt = idx_dec;
      salist_pkg::ST_DN_RD: begin
        if (!dn_more) begin
          cnt_nxt = cnt_r - CW'(1);
          ok_nxt  = 1'b1;
        end
      end
      salist_pkg::ST_DN_WR: idx_nxt = idx_inc;
      salist_pkg::ST_WRITE: begin
        cnt_nxt = cnt_r + CW'(1);
        ok_nxt  = 1'b1;
      end
      salist_pkg::ST_READ: begin
        ok_nxt   = 1'b1;
        fkey_nxt = rd_key;
        fpay_nxt = rd_pay;
      end
      default: ;
    endcase
  end

  // memory and handshake outputs
  always_comb begin
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = idx_r[AW-1:0];
    mem_wr_en   = 1'b0;
    mem_wr_addr = idx_r[AW-1:0];
    mem_wr_data = mem_rd_data;
    case (state_r)
      salist_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        mem_rd_en   = in_valid && (in_action == salist_pkg::OP_READ_POS) && pos_ok;
        mem_rd_addr = pos_m1[AW-1:0];
      end
      salist_pkg::ST_SCAN_RD: mem_rd_en = scan_more;
      salist_pkg::ST_UP_RD: begin
        mem_rd_en   = up_more;
        mem_rd_addr = idx_dec[AW-1:0];
      end
      salist_pkg::ST_DN_RD: begin
        mem_rd_en   = dn_more;
        mem_rd_addr = idx_inc[AW-1:0];
      end
      salist_pkg::ST_UP_WR, salist_pkg::ST_DN_WR: mem_wr_en = 1'b1;
      salist_pkg::ST_WRITE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = tgt_r[AW-1:0];
        mem_wr_data = {pay_r, key_r};
      end
      salist_pkg::ST_RESP: res_valid = 1'b1;
      default: ;
    endcase
  end

  // result fields
  assign res_stat.ok          = ok_r;
  assign res_stat.entry_count = salist_pkg::CNT_BITS'(cnt_r);
  assign res_stat.is_full     = full_w;
  assign res_stat.is_empty    = empty_w;
  assign res_key              = fkey_r;
  assign res_payload          = fpay_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= salist_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // per-item registers
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    pay_r  <= pay_nxt;
    idx_r  <= idx_nxt;
    tgt_r  <= tgt_nxt;
    ok_r   <= ok_nxt;
    fkey_r <= fkey_nxt;
    fpay_r <= fpay_nxt;
  end

endmodule

>>> rtl/salist_out.sv
// ----------------------------------------------------------------------------
// salist_out
// Output register: holds one finished result item until the sink takes it.
// ----------------------------------------------------------------------------
module salist_out #(
  parameter int PAYLOAD_BITS = salist_pkg::PAYLOAD_BITS_DEF,
  parameter int OUT_W        = 112
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            res_valid,
  output logic                            res_ready,
  input  salist_pkg::res_stat_t           res_stat,
  input  logic [salist_pkg::KEY_BITS-1:0] res_key,
  input  logic [PAYLOAD_BITS-1:0]         res_payload,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_W-1:0]                out_tdata,
  output logic [0:0]                      out_tuser
);

  logic                            vld_r, vld_nxt;
  logic                            load;
  salist_pkg::res_stat_t           stat_r;
  logic [salist_pkg::KEY_BITS-1:0] key_r;
  logic [PAYLOAD_BITS-1:0]         pay_r;

  // slot is free when empty or drained this cycle
  assign res_ready = !vld_r || out_tready;
  assign load      = res_valid && res_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stat_r <= res_stat;
      key_r  <= res_key;
      pay_r  <= res_payload;
    end
  end

  // pack result item
  assign out_tvalid = vld_r;
  assign out_tuser  = stat_r.ok;
  assign out_tdata  = OUT_W'({stat_r.is_empty, stat_r.is_full, stat_r.entry_count,
                              pay_r, key_r});

endmodule

>>> rtl/sorted_array_list_engine_core.sv
// ----------------------------------------------------------------------------
// sorted_array_list_engine_core
// Contiguous list of keyed records held in one memory, with end, front and
// sorted inserts, removes, positional reads and key lookups.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | content
//  --------+-----------+----------------------+------------------------------
//  in_     | sink      | in_tvalid/in_tready  | one operation item
//  out_    | source    | out_tvalid/out_tready| one result item per operation
//
// One item at a time, sequenced over the record memory, which has one write port
// and one read port with registered read data; scans and shifts step through
// the memory one entry at a time.
// Reset (rst_n low, synchronous) empties the list; no clearing pass is run.
// A stalled output holds its item in the output register while the next
// item is already taken in; the sequencer waits only if that register is full.
// ----------------------------------------------------------------------------
module sorted_array_list_engine_core #(
  parameter int DEPTH        = salist_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = salist_pkg::PAYLOAD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // key [31:0], payload, position
  input  logic [((salist_pkg::KEY_BITS + PAYLOAD_BITS + salist_pkg::POS_BITS + 7) / 8) * 8 - 1:0]
               in_tdata,
  // action [2:0]
  input  logic [salist_pkg::ACT_BITS-1:0] in_tuser,
  input  logic in_tvalid,
  output logic in_tready,
  // found_key [31:0], found_payload, entry_count, is_full, is_empty
  output logic [((salist_pkg::KEY_BITS + PAYLOAD_BITS + salist_pkg::CNT_BITS + 2 + 7) / 8) * 8
                - 1:0] out_tdata,
  // ok
  output logic [0:0] out_tuser,
  output logic out_tvalid,
  input  logic out_tready
);

  localparam int KW    = salist_pkg::KEY_BITS;
  localparam int MW    = KW + PAYLOAD_BITS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OUT_W = ((KW + PAYLOAD_BITS + salist_pkg::CNT_BITS + 2 + 7) / 8) * 8;

  logic                  mem_rd_en, mem_wr_en;
  logic [AW-1:0]         mem_rd_addr, mem_wr_addr;
  logic [MW-1:0]         mem_rd_data, mem_wr_data;
  logic                  res_valid, res_ready;
  salist_pkg::res_stat_t res_stat;
  logic [KW-1:0]         res_key;
  logic [PAYLOAD_BITS-1:0] res_payload;

  salist_seq #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_action   (salist_pkg::action_t'(in_tuser)),
    .in_key      (in_tdata[KW-1:0]),
    .in_payload  (in_tdata[KW +: PAYLOAD_BITS]),
    .in_position (in_tdata[MW +: salist_pkg::POS_BITS]),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_stat    (res_stat),
    .res_key     (res_key),
    .res_payload (res_payload)
  );

  salist_store #(
    .DEPTH (DEPTH),
    .WIDTH (MW)
  ) u_store (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  salist_out #(
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .OUT_W        (OUT_W)
  ) u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_stat    (res_stat),
    .res_key     (res_key),
    .res_payload (res_payload),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

>>> rtl/salist_chk.sv
// ----------------------------------------------------------------------------
// salist_chk
// Port-level checks for the sorted array list engine, bound to the top level.
// ----------------------------------------------------------------------------
module salist_chk #(
  parameter int DEPTH        = salist_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = salist_pkg::PAYLOAD_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic [((salist_pkg::KEY_BITS + PAYLOAD_BITS + salist_pkg::POS_BITS + 7) / 8) * 8 - 1:0]
              in_tdata,
  input logic [salist_pkg::ACT_BITS-1:0] in_tuser,
  input logic in_tvalid,
  input logic in_tready,
  input logic [((salist_pkg::KEY_BITS + PAYLOAD_BITS + salist_pkg::CNT_BITS + 2 + 7) / 8) * 8
               - 1:0] out_tdata,
  input logic [0:0] out_tuser,
  input logic out_tvalid,
  input logic out_tready
);

  localparam int CNT_LO = salist_pkg::KEY_BITS + PAYLOAD_BITS;
  localparam int FULL_B = CNT_LO + salist_pkg::CNT_BITS;
  localparam int EMPT_B = FULL_B + 1;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  // one item in flight: intake closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

  // a list is never full and empty at once
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[FULL_B] && out_tdata[EMPT_B]))
    else $error("full and empty reported together");

  // empty flag agrees with the count when the count is not masked
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (DEPTH < 128) && out_tvalid |->
      (out_tdata[EMPT_B] == (out_tdata[CNT_LO +: salist_pkg::CNT_BITS] == '0)))
    else $error("empty flag disagrees with entry count");

endmodule

bind sorted_array_list_engine_core salist_chk #(
  .DEPTH        (DEPTH),
  .PAYLOAD_BITS (PAYLOAD_BITS)
) u_chk (.*);

>>> dv/sorted_array_list_engine_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_array_list_engine_core_test
// Self-checking bench for the keyed record list. Every accepted operation
// item is replayed on a mirror of the list kept in the bench, and the
// expected result items are compared field by field with what the core
// returns. A directed opening covers empty and boundary cases, then random
// traffic grows the list to full and drains it to empty under varying
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module sorted_array_list_engine_core_test;

  localparam int KEY_BITS    = salist_pkg::KEY_BITS;
  localparam int POS_BITS    = salist_pkg::POS_BITS;
  localparam int CNT_BITS    = salist_pkg::CNT_BITS;
  localparam int LIST_DEPTH  = salist_pkg::DEPTH_DEF;
  localparam int PAY_BITS    = salist_pkg::PAYLOAD_BITS_DEF;
  localparam int IN_W        = ((KEY_BITS + PAY_BITS + POS_BITS + 7) / 8) * 8;
  localparam int OUT_W       = ((KEY_BITS + PAY_BITS + CNT_BITS + 2 + 7) / 8) * 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 138;

  // expected content of one result item
  typedef struct {
    logic                ok;
    logic [KEY_BITS-1:0] key;
    logic [PAY_BITS-1:0] payload;
    logic [CNT_BITS-1:0] count;
    logic                full;
    logic                empty;
  } list_result_t;

  // mirror of the record list plus the queue of results still owed
  class list_mirror;
    logic signed [KEY_BITS-1:0] keys[LIST_DEPTH];
    logic [PAY_BITS-1:0]        pays[LIST_DEPTH];
    int                         count;
    int                         errors;
    list_result_t               owed[$];

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // index of first record with this key, count when absent
    function int locate(logic signed [KEY_BITS-1:0] key);
      int at;
      at = 0;
      while (at < count && keys[at] != key) at++;
      return at;
    endfunction

    // remove record at index, pulling later ones forward
    function void drop(int at);
      for (int k = at; k + 1 < count; k++) begin
        keys[k] = keys[k+1];
        pays[k] = pays[k+1];
      end
      count--;
    endfunction

    // replay one accepted operation and queue its result
    function void apply_op(salist_pkg::action_t act, logic signed [KEY_BITS-1:0] key,
                           logic [PAY_BITS-1:0] pay, logic [POS_BITS-1:0] pos);
      list_result_t r;
      int at;
      r.ok      = 1'b0;
      r.key     = '0;
      r.payload = '0;
      case (act)
        salist_pkg::OP_INS_END, salist_pkg::OP_INS_FRONT, salist_pkg::OP_INS_SORTED: begin
          if (count < LIST_DEPTH) begin
            if (act == salist_pkg::OP_INS_END) at = count;
            else if (act == salist_pkg::OP_INS_FRONT) at = 0;
            else begin
              // first slot whose key is not smaller
              at = 0;
              while (at < count && keys[at] < key) at++;
            end
            for (int k = count; k > at; k--) begin
              keys[k] = keys[k-1];
              pays[k] = pays[k-1];
            end
            keys[at] = key;
            pays[at] = pay;
            count++;
            r.ok = 1'b1;
          end
        end
        salist_pkg::OP_RM_KEY: begin
          at = locate(key);
          if (at < count) begin
            drop(at);
            r.ok = 1'b1;
          end
        end
        salist_pkg::OP_RM_FRONT: begin
          if (count > 0) begin
            drop(0);
            r.ok = 1'b1;
          end
        end
        salist_pkg::OP_RM_END: begin
          if (count > 0) begin
            count--;
            r.ok = 1'b1;
          end
        end
        salist_pkg::OP_READ_POS: begin
          if (pos >= 1 && pos <= count) begin
            r.key     = keys[pos-1];
            r.payload = pays[pos-1];
            r.ok      = 1'b1;
          end
        end
        default: begin
          at = locate(key);
          if (at < count) begin
            r.key     = keys[at];
            r.payload = pays[at];
            r.ok      = 1'b1;
          end
        end
      endcase
      r.count = CNT_BITS'(count);
      r.full  = (count == LIST_DEPTH);
      r.empty = (count == 0);
      owed.push_back(r);
    endfunction

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // compare one returned item with the oldest owed result
    task check_result(logic ok, logic [OUT_W-1:0] data);
      list_result_t w;
      if (owed.size() == 0) begin
        report("result item with nothing owed");
      end else begin
        w = owed.pop_front();
        compare_field("ok", ok, w.ok);
        compare_field("found_key", data[31:0], w.key);
        compare_field("found_payload", data[95:32], w.payload);
        compare_field("entry_count", data[102:96], w.count);
        compare_field("is_full", data[103], w.full);
        compare_field("is_empty", data[104], w.empty);
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic [IN_W-1:0]     in_tdata = '0;
  salist_pkg::action_t in_tuser = salist_pkg::OP_INS_END;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [OUT_W-1:0]    out_tdata;
  logic [0:0]          out_tuser;
  logic                out_tvalid;
  logic                out_tready = 1'b0;

  list_mirror sb;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  bit         hold_armed = 1'b0;
  bit         growing = 1'b1;

  sorted_array_list_engine_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, or one long hold-off when armed
  initial begin
    forever begin
      @(posedge clk);
      if (hold_armed) begin
        hold_armed = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser[0], out_tdata);
  end

  // watchdog on cycles with no item moving on either side
  initial begin
    int quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("sorted_array_list_engine_core_test NOT OK");
    $finish;
  end

  // offer one operation item and wait for it to be taken
  task send_item(salist_pkg::action_t act, logic [KEY_BITS-1:0] key,
                 logic [PAY_BITS-1:0] pay, logic [POS_BITS-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {1'b0, pos, pay, key};
    do @(posedge clk); while (!in_tready);
    sb.apply_op(act, key, pay, pos);
  endtask

  // keys biased toward ones already stored and a small cluster around zero
  function automatic logic [KEY_BITS-1:0] pick_key();
    int sel;
    sel = $urandom_range(99);
    if (sb.count > 0 && sel < 50) return sb.keys[$urandom_range(sb.count - 1)];
    if (sel < 80) return int'($urandom_range(16)) - 8;
    return $urandom;
  endfunction

  // one random operation, steered to grow the list to full or drain it
  task random_op();
    salist_pkg::action_t act;
    int roll;
    logic [POS_BITS-1:0] pos;
    if (sb.count == LIST_DEPTH && $urandom_range(3) == 0) growing = 1'b0;
    if (sb.count == 0 && $urandom_range(3) == 0) growing = 1'b1;
    roll = $urandom_range(99);
    if (growing) begin
      if (roll < 70) act = salist_pkg::action_t'($urandom_range(2));
      else act = salist_pkg::action_t'($urandom_range(7, 3));
    end else begin
      if (roll < 15) act = salist_pkg::action_t'($urandom_range(2));
      else if (roll < 75) act = salist_pkg::action_t'($urandom_range(5, 3));
      else act = salist_pkg::action_t'($urandom_range(7, 6));
    end
    if ($urandom_range(9) < 7) pos = POS_BITS'($urandom_range(sb.count + 1));
    else pos = POS_BITS'($urandom_range(127));
    send_item(act, pick_key(), {$urandom, $urandom}, pos);
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty list: every remove, read and find fails
    send_item(salist_pkg::OP_RM_FRONT, 32'd0, 64'd0, 7'd0);
    send_item(salist_pkg::OP_RM_END, 32'd0, 64'd0, 7'd0);
    send_item(salist_pkg::OP_RM_KEY, 32'd5, 64'd0, 7'd0);
    send_item(salist_pkg::OP_FIND_KEY, 32'd0, 64'd0, 7'd0);
    send_item(salist_pkg::OP_READ_POS, 32'd0, 64'd0, 7'd0);
    send_item(salist_pkg::OP_READ_POS, 32'd0, 64'd0, 7'd1);
    // key and payload extremes, duplicates in sorted order
    send_item(salist_pkg::OP_INS_END, 32'h7fff_ffff, '1, 7'd0);
    send_item(salist_pkg::OP_INS_FRONT, 32'h8000_0000, 64'd0, 7'd127);
    send_item(salist_pkg::OP_INS_SORTED, 32'd0, 64'h0123_4567_89ab_cdef, 7'd0);
    send_item(salist_pkg::OP_INS_SORTED, 32'd0, 64'hfedc_ba98_7654_3210, 7'd0);
    send_item(salist_pkg::OP_INS_SORTED, 32'hffff_ffff, 64'h5555_aaaa_5555_aaaa, 7'd0);
    // reads at position zero, first, last and beyond
    send_item(salist_pkg::OP_READ_POS, 32'd0, 64'd0, 7'd0);
    send_item(salist_pkg::OP_READ_POS, 32'd0, 64'd0, 7'd1);
    send_item(salist_pkg::OP_READ_POS, 32'd0, 64'd0, 7'd5);
    send_item(salist_pkg::OP_READ_POS, 32'd0, 64'd0, 7'd6);
    send_item(salist_pkg::OP_READ_POS, 32'd0, 64'd0, 7'd127);
    // first match on duplicate keys, missing keys, removes by key, at the front and end
    send_item(salist_pkg::OP_FIND_KEY, 32'd0, 64'd0, 7'd0);
    send_item(salist_pkg::OP_FIND_KEY, 32'd12345, 64'd0, 7'd0);
    send_item(salist_pkg::OP_RM_KEY, 32'd0, 64'd0, 7'd0);
    send_item(salist_pkg::OP_RM_KEY, 32'd777, 64'd0, 7'd0);
    send_item(salist_pkg::OP_RM_FRONT, 32'd0, 64'd0, 7'd0);
    send_item(salist_pkg::OP_RM_END, 32'd0, 64'd0, 7'd0);
    send_item(salist_pkg::OP_FIND_KEY, 32'd0, 64'd0, 7'd0);
    send_item(salist_pkg::OP_INS_END, 32'h8000_0000, '1, 7'd64);

    // random traffic under four idling mixes; long hold-off in the first
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_armed     = 1'b1;
        end
        1: begin
          send_idle_pct  = 65;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 65;
        end
        default: begin
          send_idle_pct  = 17;
          recv_stall_pct = 17;
        end
      endcase
      repeat (PHASE_ITEMS) random_op();
    end
    in_tvalid <= 1'b0;

    // drain owed results, then allow one worst-case operation of slack
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * LIST_DEPTH + 8) @(posedge clk);
    if (sb.pending() != 0) sb.report("results still owed at end");
    if (sb.errors == 0) $display("sorted_array_list_engine_core_test OK");
    else $display("sorted_array_list_engine_core_test NOT OK");
    $finish;
  end

endmodule
